FILE: design/pip_pkg.sv
// shared types, constants and helpers for the projectile intercept predictor
package pip_pkg;

  localparam int ITERATIONS = 10;
  localparam int ITER_W     = $clog2(ITERATIONS + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int T_W    = 24;
  localparam int EFF_W  = 21;
  localparam int SQ_W   = 36;
  localparam int ROOT_W = 18;
  localparam int DIST_W = 19;
  localparam int REM_W  = 20;
  localparam int QUO_W  = 36;
  localparam int T2_W   = 33;
  localparam int SUM_W  = 52;

  localparam logic [T_W-1:0] TMAX = {T_W{1'b1}};

  localparam logic [1:0] REG_EMITTER_X = 2'd0;
  localparam logic [1:0] REG_EMITTER_Y = 2'd1;
  localparam logic [1:0] REG_SPEED     = 2'd2;
  localparam logic [1:0] REG_GAIN      = 2'd3;

  localparam logic OP_AIM     = 1'b0;
  localparam logic OP_CONTOUR = 1'b1;

  typedef struct packed {
    logic signed [15:0] emitter_x;
    logic signed [15:0] emitter_y;
    logic        [15:0] projectile_speed;
    logic        [15:0] latency_gain;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic        [1:0]  last_corner;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic [EFF_W-1:0]   eff;
  } item_t;

  // clamp a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    logic signed [15:0] r;
    if (v > 35'sd32767) r = 16'sh7FFF;
    else if (v < -35'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

FILE: design/pip_front.sv
// front end: accepts items, works out the latency term and corner count, queues them
module pip_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic signed [15:0]  vel_x,
  input  logic signed [15:0]  vel_y,
  input  logic signed [15:0]  acc_x,
  input  logic signed [15:0]  acc_y,
  input  logic [15:0]         dt,
  input  logic [15:0]         latency_gain,
  output logic                q_valid,
  output pip_pkg::item_t      q_item,
  input  logic                q_take
);

  pip_pkg::item_t             slots [pip_pkg::QDEPTH];
  logic [pip_pkg::QPTR_W-1:0] wr_ptr;
  logic [pip_pkg::QPTR_W-1:0] rd_ptr;
  logic [pip_pkg::QCNT_W-1:0] count;
  logic                       push;
  logic                       pop;
  logic [32:0]                eff_full;
  pip_pkg::item_t             new_item;

  assign in_stall = (count == pip_pkg::QCNT_W'(pip_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_take && q_valid;
  assign q_item   = slots[rd_ptr];

  // latency term, rounded to Q5.16
  assign eff_full = {1'b0, 32'(dt) * 32'(latency_gain)} + 33'd2048;

  // classify: aim gives one point, contour gives four
  always_comb begin
    new_item.op          = op;
    new_item.last_corner = (op == pip_pkg::OP_CONTOUR) ? 2'd3 : 2'd0;
    new_item.pos_x       = pos_x;
    new_item.pos_y       = pos_y;
    new_item.vel_x       = vel_x;
    new_item.vel_y       = vel_y;
    new_item.acc_x       = acc_x;
    new_item.acc_y       = acc_y;
    new_item.eff         = eff_full[32:12];
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // assertions
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == pip_pkg::QCNT_W'(pip_pkg::QDEPTH)) |-> !push)
    else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pip_pkg::QCNT_W'(pip_pkg::QDEPTH))
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

FILE: design/pip_back.sv
// back end: iterative flight time refinement per point and the output register
module pip_back (
  input  logic               clk,
  input  logic               rst,
  input  pip_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  pip_pkg::item_t     q_item,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pred_x,
  output logic signed [15:0] pred_y,
  output logic [1:0]         corner,
  output logic               last
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_SQX  = 14'b00000000000010,
    S_SQY  = 14'b00000000000100,
    S_SQRT = 14'b00000000001000,
    S_DIV  = 14'b00000000010000,
    S_TADD = 14'b00000000100000,
    S_T2   = 14'b00000001000000,
    S_MVX  = 14'b00000010000000,
    S_MAX  = 14'b00000100000000,
    S_SUMX = 14'b00001000000000,
    S_MVY  = 14'b00010000000000,
    S_MAY  = 14'b00100000000000,
    S_SUMY = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t                          state;
  pip_pkg::item_t                  item;
  logic [1:0]                      cur_corner;
  logic [pip_pkg::ITER_W-1:0]      iter;
  logic [5:0]                      steps;
  logic signed [16:0]              px0;
  logic signed [16:0]              py0;
  logic signed [16:0]              cx;
  logic signed [16:0]              cy;
  logic [pip_pkg::SQ_W-1:0]        rad;
  logic [pip_pkg::ROOT_W-1:0]      root;
  logic [pip_pkg::REM_W-1:0]       srem;
  logic [pip_pkg::QUO_W-1:0]       num;
  logic [16:0]                     drem;
  logic [pip_pkg::QUO_W-1:0]       quo;
  logic [pip_pkg::T_W-1:0]         t;
  logic [pip_pkg::T2_W-1:0]        t2;
  logic signed [40:0]              prod_v;
  logic signed [49:0]              prod_a;
  logic signed [15:0]              nx;
  logic signed [15:0]              ny;

  logic signed [17:0]              dx;
  logic signed [17:0]              dy;
  logic signed [35:0]              dsq;
  logic [15:0]                     speed;
  logic [pip_pkg::REM_W+1:0]       srem_sh;
  logic [pip_pkg::REM_W+1:0]       trial;
  logic [pip_pkg::DIST_W-1:0]      root_rnd;
  logic [17:0]                     drem_sh;
  logic [pip_pkg::T_W-1:0]         q_sat;
  logic [pip_pkg::T_W:0]           t_sum;
  logic [48:0]                     tt;
  logic signed [15:0]              vsel;
  logic signed [15:0]              asel;
  logic signed [16:0]              psel;
  logic signed [pip_pkg::SUM_W-1:0] sum;
  logic signed [15:0]              axis_res;
  logic                            out_free;
  logic                            start_item;
  logic signed [16:0]              ofs_x;
  logic signed [16:0]              ofs_y;
  logic [1:0]                      next_corner;
  logic                            next_op;
  pip_pkg::item_t                  next_item;

  assign out_free   = !out_valid || !out_stall;
  assign start_item = (state == S_IDLE) && q_valid;
  assign q_take     = start_item;

  // distance terms against the emitter
  assign dx  = 18'(cx) - 18'(cfg.emitter_x);
  assign dy  = 18'(cy) - 18'(cfg.emitter_y);
  assign dsq = (state == S_SQX) ? dx * dx : dy * dy;

  // one square root digit per cycle
  assign srem_sh  = {srem, rad[pip_pkg::SQ_W-1 -: 2]};
  assign trial    = {2'b00, root, 2'b01};
  assign root_rnd = ({1'b0, srem} > {2'b00, root}) ? pip_pkg::DIST_W'(root) + 1'b1
                                                   : pip_pkg::DIST_W'(root);

  // one quotient bit per cycle, zero speed acts as one
  assign speed   = (cfg.projectile_speed == '0) ? 16'd1 : cfg.projectile_speed;
  assign drem_sh = {drem, num[pip_pkg::QUO_W-1]};

  // flight time with saturation
  assign q_sat = (quo > pip_pkg::QUO_W'(pip_pkg::TMAX)) ? pip_pkg::TMAX
                                                       : quo[pip_pkg::T_W-1:0];
  assign t_sum = {1'b0, q_sat} + (pip_pkg::T_W+1)'(item.eff);
  assign tt    = {1'b0, 48'(t) * 48'(t)} + 49'd32768;

  // axis prediction, shared between x and y
  assign vsel = (state == S_MVX) ? item.vel_x : item.vel_y;
  assign asel = (state == S_MAX) ? item.acc_x : item.acc_y;
  assign psel = (state == S_SUMX) ? px0 : py0;
  assign sum  = (pip_pkg::SUM_W'(psel) <<< 17) + (pip_pkg::SUM_W'(prod_v) <<< 1)
              + pip_pkg::SUM_W'(prod_a) + pip_pkg::SUM_W'(65536);
  assign axis_res = pip_pkg::sat16(sum[pip_pkg::SUM_W-1:17]);

  // point offsets for the next corner
  assign next_item   = start_item ? q_item : item;
  assign next_corner = start_item ? 2'd0 : cur_corner + 1'b1;
  assign next_op     = next_item.op;
  always_comb begin
    if (next_op == pip_pkg::OP_AIM) begin
      ofs_x = 17'sd0;
      ofs_y = 17'sd16;
    end else begin
      ofs_x = next_corner[0] ? 17'sd32 : -17'sd32;
      ofs_y = next_corner[1] ? -17'sd16 : 17'sd16;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item       <= q_item;
            cur_corner <= 2'd0;
            px0        <= 17'(q_item.pos_x) + ofs_x;
            py0        <= 17'(q_item.pos_y) + ofs_y;
            cx         <= 17'(q_item.pos_x) + ofs_x;
            cy         <= 17'(q_item.pos_y) + ofs_y;
            iter       <= '0;
            state      <= S_SQX;
          end
        end
        S_SQX: begin
          rad   <= dsq[pip_pkg::SQ_W-1:0];
          state <= S_SQY;
        end
        S_SQY: begin
          rad   <= rad + dsq[pip_pkg::SQ_W-1:0];
          root  <= '0;
          srem  <= '0;
          steps <= 6'(pip_pkg::SQ_W / 2 - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (srem_sh >= trial) begin
            srem <= pip_pkg::REM_W'(srem_sh - trial);
            root <= {root[pip_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            srem <= pip_pkg::REM_W'(srem_sh);
            root <= {root[pip_pkg::ROOT_W-2:0], 1'b0};
          end
          rad <= rad << 2;
          if (steps == '0) state <= S_DIV;
          // wraps to all ones on the last digit, which marks the divider load
          steps <= steps - 1'b1;
        end
        S_DIV: begin
          if (steps == 6'h3F) begin
            // first cycle here: load the dividend from the rounded root
            num   <= {1'b0, root_rnd, 16'b0} + pip_pkg::QUO_W'(speed >> 1);
            drem  <= '0;
            quo   <= '0;
            steps <= 6'(pip_pkg::QUO_W - 1);
          end else begin
            if (drem_sh >= {2'b00, speed}) begin
              drem <= 17'(drem_sh - {2'b00, speed});
              quo  <= {quo[pip_pkg::QUO_W-2:0], 1'b1};
            end else begin
              drem <= drem_sh[16:0];
              quo  <= {quo[pip_pkg::QUO_W-2:0], 1'b0};
            end
            num <= num << 1;
            if (steps == '0) state <= S_TADD;
            steps <= steps - 1'b1;
          end
        end
        S_TADD: begin
          t     <= t_sum[pip_pkg::T_W] ? pip_pkg::TMAX : t_sum[pip_pkg::T_W-1:0];
          state <= S_T2;
        end
        S_T2: begin
          t2    <= tt[48:16];
          state <= S_MVX;
        end
        S_MVX: begin
          prod_v <= vsel * $signed({1'b0, t});
          state  <= S_MAX;
        end
        S_MAX: begin
          prod_a <= asel * $signed({1'b0, t2});
          state  <= S_SUMX;
        end
        S_SUMX: begin
          nx    <= axis_res;
          state <= S_MVY;
        end
        S_MVY: begin
          prod_v <= vsel * $signed({1'b0, t});
          state  <= S_MAY;
        end
        S_MAY: begin
          prod_a <= asel * $signed({1'b0, t2});
          state  <= S_SUMY;
        end
        S_SUMY: begin
          ny <= axis_res;
          if (iter == pip_pkg::ITER_W'(pip_pkg::ITERATIONS)) begin
            state <= S_OUT;
          end else begin
            iter  <= iter + 1'b1;
            cx    <= 17'(nx);
            cy    <= 17'(axis_res);
            state <= S_SQX;
          end
        end
        S_OUT: begin
          if (out_free) begin
            pred_x    <= nx;
            pred_y    <= ny;
            corner    <= cur_corner;
            last      <= (cur_corner == item.last_corner);
            if (cur_corner == item.last_corner) begin
              state <= S_IDLE;
            end else begin
              cur_corner <= next_corner;
              px0        <= 17'(item.pos_x) + ofs_x;
              py0        <= 17'(item.pos_y) + ofs_y;
              cx         <= 17'(item.pos_x) + ofs_x;
              cy         <= 17'(item.pos_y) + ofs_y;
              iter       <= '0;
              state      <= S_SQX;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= pip_pkg::ITER_W'(pip_pkg::ITERATIONS))
    else $error("iteration count out of range");
  a_tadd_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_TADD) |-> ($past(state) == S_DIV))
    else $error("flight time taken without a finished division");
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (corner != 2'd3))
    else $error("final corner sent without last");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pred_x) && $stable(corner)))
    else $error("stalled result changed");

endmodule

FILE: design/projectile_intercept_predictor.sv
// top level of the projectile intercept predictor
//
// Input channel (in_valid / in_stall): one target item per transfer, with op
// selecting a single aim point (one result) or a four-corner contour (four
// results, corner 0..3). Output channel (out_valid / out_stall): one predicted
// point per transfer, last marks the final result of an item.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
// emitter_x, emitter_y, projectile_speed and latency_gain; cfg_ready is always
// high and writes are expected only while the block is idle.
// Each point runs eleven flight time evaluations (squaring the x and y distances,
// one root digit per cycle, loading the divider, then one quotient bit per cycle,
// then the add), each followed by a position update (time squared, then velocity,
// acceleration and sum for x and for y), then the output state. The idle state
// takes the item from the queue, and the back finishes every point of an item
// before it takes the next. Most of the work per evaluation lies in the shared
// iterative root and divide unit. A two-entry queue lets the front take further
// items while the back works, and the output register holds a result while the
// receiver stalls, which pauses the back only.
// Reset (synchronous, active high) empties the queue, drops any pending
// result and restores the register defaults.
module projectile_intercept_predictor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic [15:0]        dt,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pred_x,
  output logic signed [15:0] pred_y,
  output logic [1:0]         corner,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  pip_pkg::cfg_t  cfg;
  logic           q_valid;
  pip_pkg::item_t q_item;
  logic           q_take;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.emitter_x        <= 16'sd0;
      cfg.emitter_y        <= 16'sd0;
      cfg.projectile_speed <= 16'd600;
      cfg.latency_gain     <= 16'd39322;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pip_pkg::REG_EMITTER_X: cfg.emitter_x        <= cfg_data;
        pip_pkg::REG_EMITTER_Y: cfg.emitter_y        <= cfg_data;
        pip_pkg::REG_SPEED:     cfg.projectile_speed <= cfg_data;
        pip_pkg::REG_GAIN:      cfg.latency_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  pip_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .acc_x        (acc_x),
    .acc_y        (acc_y),
    .dt           (dt),
    .latency_gain (cfg.latency_gain),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_take       (q_take)
  );

  pip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pred_x    (pred_x),
    .pred_y    (pred_y),
    .corner    (corner),
    .last      (last)
  );

endmodule

FILE: dv/tb_top.sv
// testbench for the projectile intercept predictor: directed table, then random targets
`timescale 1ns / 100ps

module tb_top;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               op;
  logic signed [15:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic [15:0]        dt;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] pred_x, pred_y;
  logic [1:0]         corner;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  typedef struct {
    logic               op;
    logic signed [15:0] px, py, vx, vy, ax, ay;
    logic [15:0]        dt;
    bit                 typed;
    logic signed [15:0] ex, ey;
  } target_row_t;

  typedef struct {
    logic signed [15:0] x, y;
    logic [1:0]         corner;
    logic               last;
  } point_t;

  // shadow copy of the block's registers
  longint  emit_x, emit_y;
  longint  speed, gain;
  point_t  pending_points[$];
  int      fail_count;
  int      items_sent, points_seen;
  bit      calm;

  projectile_intercept_predictor dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint root_round(longint unsigned d);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > d) b >>= 2;
    while (b != 0) begin
      if (d >= r + b) begin
        d = d - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (d > r) r++;
    return longint'(r);
  endfunction

  // flight time in Q8.16 seconds, saturated
  function automatic longint flight_q16(longint px, longint py, longint eff);
    longint dx, dy, range_px, s, q, t;
    dx = px - emit_x;
    dy = py - emit_y;
    range_px = root_round(longint'(dx * dx + dy * dy));
    s = (speed == 0) ? 1 : speed;
    q = ((range_px << 16) + (s >> 1)) / s;
    if (q > 64'hFFFFFF) q = 64'hFFFFFF;
    t = q + eff;
    return (t > 64'hFFFFFF) ? 64'hFFFFFF : t;
  endfunction

  function automatic longint axis_at(longint p, longint v, longint a, longint t, longint t2);
    longint sum, r;
    sum = p * 131072 + 2 * v * t + a * t2;
    r = (sum + 65536) >>> 17;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // predict one intercept point and queue it
  task automatic queue_intercept(longint px, longint py, target_row_t r, longint eff,
                                 int k, bit fin);
    longint t, t2, x, y;
    point_t pt;
    t = flight_q16(px, py, eff);
    for (int i = 0; i <= pip_pkg::ITERATIONS; i++) begin
      t2 = (t * t + 32768) >> 16;
      x = axis_at(px, r.vx, r.ax, t, t2);
      y = axis_at(py, r.vy, r.ay, t, t2);
      if (i < pip_pkg::ITERATIONS) t = flight_q16(x, y, eff);
    end
    pt.x = x[15:0];
    pt.y = y[15:0];
    pt.corner = k[1:0];
    pt.last = fin;
    pending_points.push_back(pt);
  endtask

  task automatic queue_results(target_row_t r);
    longint eff;
    point_t pt;
    longint ox[4] = '{-32, 32, -32, 32};
    longint oy[4] = '{16, 16, -16, -16};
    eff = (longint'(r.dt) * gain + 2048) >> 12;
    if (r.op == pip_pkg::OP_AIM) begin
      if (r.typed) begin
        pt.x = r.ex;
        pt.y = r.ey;
        pt.corner = 2'd0;
        pt.last = 1'b1;
        pending_points.push_back(pt);
      end else begin
        queue_intercept(r.px, longint'(r.py) + 16, r, eff, 0, 1'b1);
      end
    end else begin
      for (int k = 0; k < 4; k++)
        queue_intercept(longint'(r.px) + ox[k], longint'(r.py) + oy[k], r, eff, k, k == 3);
    end
  endtask

  // one target transfer, with random idle cycles before it unless calm is set
  task automatic send_target(target_row_t r);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= r.op;
    pos_x <= r.px;
    pos_y <= r.py;
    vel_x <= r.vx;
    vel_y <= r.vy;
    acc_x <= r.ax;
    acc_y <= r.ay;
    dt <= r.dt;
    do @(posedge clk); while (in_stall);
    queue_results(r);
    items_sent++;
  endtask

  // valid stays high across back to back writes and drops after the last one
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pip_pkg::REG_EMITTER_X: emit_x = longint'(signed'(val));
      pip_pkg::REG_EMITTER_Y: emit_y = longint'(signed'(val));
      pip_pkg::REG_SPEED:     speed = val;
      pip_pkg::REG_GAIN:      gain = val;
      default: ;
    endcase
  endtask

  // let the block drain before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_settings(logic [15:0] ex, logic [15:0] ey, logic [15:0] spd,
                               logic [15:0] g);
    drain();
    write_reg(pip_pkg::REG_EMITTER_X, ex);
    write_reg(pip_pkg::REG_EMITTER_Y, ey);
    write_reg(pip_pkg::REG_SPEED, spd);
    write_reg(pip_pkg::REG_GAIN, g);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_field(int span);
    if ($urandom_range(99) < 30) return 16'($urandom);
    return 16'($urandom_range(2 * span) - span);
  endfunction

  function automatic target_row_t random_target();
    target_row_t r;
    r.op = 1'($urandom_range(1));
    r.px = pick_field(2000);
    r.py = pick_field(2000);
    r.vx = pick_field(500);
    r.vy = pick_field(500);
    r.ax = pick_field(200);
    r.ay = pick_field(200);
    r.dt = ($urandom_range(99) < 30) ? 16'($urandom) : 16'($urandom_range(2048));
    r.typed = 0;
    r.ex = 0;
    r.ey = 0;
    return r;
  endfunction

  // output side stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 32);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("unexpected result x=%0d y=%0d corner=%0d", pred_x, pred_y, corner);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (pred_x !== want.x) begin
          $error("pred_x expected %0d actual %0d", want.x, pred_x);
          fail_count++;
        end
        if (pred_y !== want.y) begin
          $error("pred_y expected %0d actual %0d", want.y, pred_y);
          fail_count++;
        end
        if (corner !== want.corner) begin
          $error("corner expected %0d actual %0d", want.corner, corner);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    target_row_t rows[$];
    rst = 1'b1;
    in_valid = 1'b0;
    op = pip_pkg::OP_AIM;
    {pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, dt} = '0;
    cfg_valid = 1'b0;
    cfg_index = pip_pkg::REG_EMITTER_X;
    cfg_data = '0;
    fail_count = 0;
    items_sent = 0;
    points_seen = 0;
    calm = 0;
    emit_x = 0;
    emit_y = 0;
    speed = 600;
    gain = 39322;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: rows marked typed give their result directly, the rest is predicted
    rows = '{
      '{pip_pkg::OP_AIM,     0, 0, 0, 0, 0, 0, 0, 1, 0, 16},
      '{pip_pkg::OP_CONTOUR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{pip_pkg::OP_AIM,     100, -50, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0},
      '{pip_pkg::OP_AIM,     32767, 32767, 0, 0, 0, 0, 0, 1, 32767, 32767},
      '{pip_pkg::OP_AIM,     -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
      '{pip_pkg::OP_CONTOUR, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
      '{pip_pkg::OP_CONTOUR, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
      '{pip_pkg::OP_AIM,     0, 0, 32767, 32767, 0, 0, 0, 0, 0, 0},
      '{pip_pkg::OP_AIM,     0, 0, -32768, -32768, 0, 0, 0, 0, 0, 0},
      '{pip_pkg::OP_AIM,     0, 0, 0, 0, 32767, 32767, 0, 0, 0, 0},
      '{pip_pkg::OP_AIM,     0, 0, 0, 0, -32768, -32768, 0, 0, 0, 0},
      '{pip_pkg::OP_CONTOUR, 32767, -32768, 32767, -32768, 32767, -32768, 16'hFFFF,
        0, 0, 0},
      '{pip_pkg::OP_CONTOUR, -32768, 32767, -32768, 32767, -32768, 32767, 16'hFFFF,
        0, 0, 0},
      '{pip_pkg::OP_AIM,     300, 200, -100, 50, 10, -20, 16'h0800, 0, 0, 0},
      '{pip_pkg::OP_CONTOUR, -400, 150, 80, -60, -5, 30, 16'h0400, 0, 0, 0},
      '{pip_pkg::OP_AIM,     20000, -20000, 1000, -1000, 300, 300, 16'h1000, 0, 0, 0}
    };
    foreach (rows[i]) send_target(rows[i]);

    // zero speed and long flight in a short directed phase
    load_settings(16'h0000, 16'h0000, 16'd0, 16'hFFFF);
    send_target(rows[2]);
    send_target(rows[11]);
    send_target(rows[13]);

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_settings(16'd0, 16'd0, 16'd600, 16'd39322);
        1: load_settings(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        2: load_settings(16'h7FFF, 16'h8000, 16'd0, 16'd0);
        3: load_settings(16'($urandom), 16'($urandom), 16'd1, 16'($urandom));
        default: load_settings(16'($urandom_range(1000)), 16'($urandom_range(1000)),
                               16'($urandom_range(2000, 100)), 16'($urandom));
      endcase
      for (int n = 0; n < 48; n++) begin
        calm = (ph == 0) && (n >= 10) && (n < 35);
        send_target(random_target());
      end
      calm = 0;
    end

    drain();
    $display("sent %0d targets and checked %0d intercept points", items_sent, points_seen);
    $display("covered aim and contour, five register settings incl. zero speed and extremes");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
